// ===== hw/rtl/ovl_pkg.sv =====
// Shared constants, codes and types of the ordered value list.
`default_nettype none

package ovl_pkg;

    // Capacity of the list
    localparam int DEPTH = 16;
    localparam int DataW = 32;
    localparam int IdxW  = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CntW  = $clog2(DEPTH + 1);

    // Command codes on the input tuser
    typedef enum logic [1:0] {
        CMD_APPEND = 2'd0,
        CMD_DELETE = 2'd1,
        CMD_READ   = 2'd2
    } t_cmd;

    // Result status codes
    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_EMPTY     = 2'd1,
        ST_NOT_FOUND = 2'd2,
        ST_FULL      = 2'd3
    } t_status;

    // Sequencer states
    typedef enum logic [2:0] {
        S_IDLE,
        S_RESP,
        S_DEL_RD,
        S_DEL_CMP,
        S_SHF_RD,
        S_SHF_WR,
        S_RO_RD,
        S_RO_OUT
    } t_state;

    // Request bundle to the entry store
    typedef struct packed {
        logic             wr_en;
        logic [IdxW-1:0]  wr_addr;
        logic [DataW-1:0] wr_data;
        logic             rd_en;
        logic [IdxW-1:0]  rd_addr;
    } t_ram_req;

endpackage

`default_nettype wire

// ===== hw/rtl/ordered_value_list.sv =====
// Append or error results go via S_RESP. One entry-store read port paces the
// delete search and shift: each entry is read, then compared, and each entry
// moved to close the gap is read, then rewritten. Read out reads each entry.
// One command at a time: s_axis_tready is high only while the sequencer is idle.
// Reset (sync, active low) empties the list and drops any pending output;
// stored entries are not cleared and need no clearing pass.
`default_nettype none

module ordered_value_list
    import ovl_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    // input command stream
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [31:0] s_axis_tdata,   // [31:0] value
    input  wire logic [1:0]  s_axis_tuser,   // [1:0] command
    // result stream
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    output logic      [31:0] m_axis_tdata,   // [31:0] entry_value
    output logic      [2:0]  m_axis_tuser,   // [1:0] status, [2] has_entry
    output logic             m_axis_tlast    // last result of the command
);

    localparam int CmpW = CntW + 1;

    // sequencer and list state
    t_state            r_state,  n_state;
    logic [CntW-1:0]   r_count,  n_count;
    logic [IdxW-1:0]   r_idx,    n_idx;
    logic [DataW-1:0]  r_value,  n_value;
    t_status           r_status, n_status;

    // output register
    logic              r_out_valid,  n_out_valid;
    t_status           r_out_status, n_out_status;
    logic              r_out_has,    n_out_has;
    logic [DataW-1:0]  r_out_val,    n_out_val;
    logic              r_out_last,   n_out_last;

    t_ram_req          ram_req;
    logic [DataW-1:0]  rd_data;

    logic              in_xfer;
    logic              slot_free;
    logic [CmpW-1:0]   cnt_ext;
    logic [CmpW-1:0]   idx_p1;
    logic [CmpW-1:0]   idx_p2;

    ovl_ram u_ram (
        .i_clk     (i_clk),
        .i_req     (ram_req),
        .o_rd_data (rd_data)
    );

    assign s_axis_tready = (r_state == S_IDLE);
    assign in_xfer       = s_axis_tvalid && s_axis_tready;
    // output register can take a new result this cycle
    assign slot_free     = !r_out_valid || m_axis_tready;

    assign cnt_ext = CmpW'(r_count);
    assign idx_p1  = CmpW'(r_idx) + CmpW'(1);
    assign idx_p2  = CmpW'(r_idx) + CmpW'(2);

    always_comb begin
        n_state      = r_state;
        n_count      = r_count;
        n_idx        = r_idx;
        n_value      = r_value;
        n_status     = r_status;
        n_out_valid  = r_out_valid && !m_axis_tready;
        n_out_status = r_out_status;
        n_out_has    = r_out_has;
        n_out_val    = r_out_val;
        n_out_last   = r_out_last;
        ram_req      = '0;

        case (r_state)
            S_IDLE: begin
                if (in_xfer) begin
                    n_value = s_axis_tdata;
                    n_idx   = '0;
                    case (s_axis_tuser)
                        CMD_APPEND: begin
                            if (cnt_ext >= CmpW'(DEPTH)) begin
                                n_status = ST_FULL;
                            end else begin
                                // tail write straight from the input transfer
                                ram_req.wr_en   = 1'b1;
                                ram_req.wr_addr = r_count[IdxW-1:0];
                                ram_req.wr_data = s_axis_tdata;
                                n_count         = r_count + CntW'(1);
                                n_status        = ST_OK;
                            end
                            n_state = S_RESP;
                        end
                        CMD_DELETE: begin
                            if (r_count == '0) begin
                                n_status = ST_EMPTY;
                                n_state  = S_RESP;
                            end else begin
                                n_state = S_DEL_RD;
                            end
                        end
                        CMD_READ: begin
                            if (r_count == '0) begin
                                n_status = ST_EMPTY;
                                n_state  = S_RESP;
                            end else begin
                                n_state = S_RO_RD;
                            end
                        end
                        default: begin
                            // unused code: dropped without a result
                            n_state = S_IDLE;
                        end
                    endcase
                end
            end
            S_RESP: begin
                if (slot_free) begin
                    n_out_valid  = 1'b1;
                    n_out_status = r_status;
                    n_out_has    = 1'b0;
                    n_out_val    = '0;
                    n_out_last   = 1'b1;
                    n_state      = S_IDLE;
                end
            end
            S_DEL_RD: begin
                ram_req.rd_en   = 1'b1;
                ram_req.rd_addr = r_idx;
                n_state         = S_DEL_CMP;
            end
            S_DEL_CMP: begin
                if (rd_data == r_value) begin
                    if (idx_p1 < cnt_ext) begin
                        n_state = S_SHF_RD;
                    end else begin
                        // match at the tail: nothing to move
                        n_count  = r_count - CntW'(1);
                        n_status = ST_OK;
                        n_state  = S_RESP;
                    end
                end else if (idx_p1 == cnt_ext) begin
                    n_status = ST_NOT_FOUND;
                    n_state  = S_RESP;
                end else begin
                    n_idx   = r_idx + IdxW'(1);
                    n_state = S_DEL_RD;
                end
            end
            S_SHF_RD: begin
                ram_req.rd_en   = 1'b1;
                ram_req.rd_addr = idx_p1[IdxW-1:0];
                n_state         = S_SHF_WR;
            end
            S_SHF_WR: begin
                ram_req.wr_en   = 1'b1;
                ram_req.wr_addr = r_idx;
                ram_req.wr_data = rd_data;
                if (idx_p2 < cnt_ext) begin
                    n_idx   = r_idx + IdxW'(1);
                    n_state = S_SHF_RD;
                end else begin
                    n_count  = r_count - CntW'(1);
                    n_status = ST_OK;
                    n_state  = S_RESP;
                end
            end
            S_RO_RD: begin
                ram_req.rd_en   = 1'b1;
                ram_req.rd_addr = r_idx;
                n_state         = S_RO_OUT;
            end
            S_RO_OUT: begin
                // read data holds while the output side stalls
                if (slot_free) begin
                    n_out_valid  = 1'b1;
                    n_out_status = ST_OK;
                    n_out_has    = 1'b1;
                    n_out_val    = rd_data;
                    n_out_last   = (idx_p1 == cnt_ext);
                    if (idx_p1 == cnt_ext) begin
                        n_state = S_IDLE;
                    end else begin
                        n_idx   = r_idx + IdxW'(1);
                        n_state = S_RO_RD;
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_count     <= n_count;
            r_out_valid <= n_out_valid;
        end
    end

    // payload
    always_ff @(posedge i_clk) begin
        r_idx        <= n_idx;
        r_value      <= n_value;
        r_status     <= n_status;
        r_out_status <= n_out_status;
        r_out_has    <= n_out_has;
        r_out_val    <= n_out_val;
        r_out_last   <= n_out_last;
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_val;
    assign m_axis_tuser  = {r_out_has, r_out_status};
    assign m_axis_tlast  = r_out_last;

`ifndef ASSERT_OFF
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        CmpW'(r_count) <= CmpW'(DEPTH))
        else $error("entry count above capacity");

    a_append_grows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_xfer && s_axis_tuser == CMD_APPEND && CmpW'(r_count) < CmpW'(DEPTH))
        |=> (r_count == $past(r_count) + CntW'(1)))
        else $error("append did not grow the list");

    a_search_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DEL_CMP || r_state == S_RO_OUT || r_state == S_SHF_WR)
        |-> (CmpW'(r_idx) < CmpW'(r_count)))
        else $error("entry index beyond list length");

    a_entry_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out_has) |-> (r_out_status == ST_OK))
        else $error("listed entry with error status");
`endif

endmodule

`default_nettype wire

// ===== hw/rtl/ovl_ram.sv =====
// Entry store: one write port, one registered read port.
`default_nettype none

module ovl_ram
    import ovl_pkg::*;
(
    input  wire logic             i_clk,
    input  wire t_ram_req         i_req,
    output logic      [DataW-1:0] o_rd_data
);

    logic [DataW-1:0] r_mem [DEPTH];
    logic [DataW-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_req.wr_en) begin
            r_mem[i_req.wr_addr] <= i_req.wr_data;
        end
    end

    // read data holds while no read is issued
    always_ff @(posedge i_clk) begin
        if (i_req.rd_en) begin
            r_rd_data <= r_mem[i_req.rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

`default_nettype wire

// ===== bench/ovl_checker.sv =====
`timescale 1ns / 1ps
// Result checker for the ordered value list: mirrors the list and compares every result transfer.

module ovl_checker
    import ovl_pkg::*;
(
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_cmd_valid,
    input  wire logic             i_cmd_ready,
    input  wire logic [DataW-1:0] i_cmd_data,   // [31:0] value
    input  wire logic [1:0]       i_cmd_user,   // [1:0] command
    input  wire logic             i_res_valid,
    input  wire logic             i_res_ready,
    input  wire logic [DataW-1:0] i_res_data,   // [31:0] entry_value
    input  wire logic [2:0]       i_res_user,   // [1:0] status, [2] has_entry
    input  wire logic             i_res_last,
    output int                    o_pending,
    output int                    o_fail_count
);

    localparam int MaxPrinted = 30;

    typedef struct {
        t_status          status;
        logic             has_entry;
        logic [DataW-1:0] entry_value;
        logic             last;
    } t_list_result;

    // expected results, oldest first
    t_list_result     awaited_results[$];
    // mirror of the list contents in list order
    logic [DataW-1:0] mirror_vals [DEPTH];
    int               mirror_len = 0;
    int               mismatches = 0;

    task automatic report_mismatch(input string what);
        if (mismatches < MaxPrinted)
            $display("%0t ns: result mismatch: %s", $time, what);
        mismatches++;
    endtask

    task automatic await_result(input t_status st, input logic has,
                                input logic [DataW-1:0] val, input logic lst);
        t_list_result r;
        r.status      = st;
        r.has_entry   = has;
        r.entry_value = val;
        r.last        = lst;
        awaited_results.push_back(r);
    endtask

    // Apply one command to the mirror and queue the results it causes
    task automatic apply_list_command(input logic [1:0] cmd, input logic [DataW-1:0] val);
        int i;
        int hit;
        hit = -1;
        case (cmd)
            CMD_APPEND: begin
                if (mirror_len >= DEPTH) begin
                    await_result(ST_FULL, 1'b0, '0, 1'b1);
                end else begin
                    mirror_vals[mirror_len] = val;
                    mirror_len++;
                    await_result(ST_OK, 1'b0, '0, 1'b1);
                end
            end
            CMD_DELETE: begin
                if (mirror_len == 0) begin
                    await_result(ST_EMPTY, 1'b0, '0, 1'b1);
                end else begin
                    // earliest match only
                    for (i = 0; i < mirror_len; i++)
                        if (hit < 0 && mirror_vals[i] == val)
                            hit = i;
                    if (hit < 0) begin
                        await_result(ST_NOT_FOUND, 1'b0, '0, 1'b1);
                    end else begin
                        for (i = hit; i < mirror_len - 1; i++)
                            mirror_vals[i] = mirror_vals[i+1];
                        mirror_len--;
                        await_result(ST_OK, 1'b0, '0, 1'b1);
                    end
                end
            end
            CMD_READ: begin
                if (mirror_len == 0) begin
                    await_result(ST_EMPTY, 1'b0, '0, 1'b1);
                end else begin
                    for (i = 0; i < mirror_len; i++)
                        await_result(ST_OK, 1'b1, mirror_vals[i], i == mirror_len - 1);
                end
            end
            default: ;   // unused code: no effect, no result
        endcase
    endtask

    always @(posedge i_clk) begin
        t_list_result want;
        if (!i_rst_n) begin
            awaited_results.delete();
            mirror_len = 0;
        end else begin
            // command side first: a result never leaves in the cycle of its own command
            if (i_cmd_valid && i_cmd_ready)
                apply_list_command(i_cmd_user, i_cmd_data);
            if (i_res_valid && i_res_ready) begin
                if (awaited_results.size() == 0) begin
                    report_mismatch($sformatf("unexpected result data %h user %b last %b",
                                              i_res_data, i_res_user, i_res_last));
                end else begin
                    want = awaited_results.pop_front();
                    if (i_res_user[1:0] !== want.status)
                        report_mismatch($sformatf("status %b, want %b",
                                                  i_res_user[1:0], want.status));
                    if (i_res_user[2] !== want.has_entry)
                        report_mismatch($sformatf("has_entry %b, want %b",
                                                  i_res_user[2], want.has_entry));
                    if (i_res_data !== want.entry_value)
                        report_mismatch($sformatf("entry_value %h, want %h",
                                                  i_res_data, want.entry_value));
                    if (i_res_last !== want.last)
                        report_mismatch($sformatf("last %b, want %b", i_res_last, want.last));
                end
            end
        end
        o_pending    <= awaited_results.size();
        o_fail_count <= mismatches;
    end

endmodule

// ===== bench/ordered_value_list_test.sv =====
`timescale 1ns / 1ps
// Top of the ordered value list bench: clock, reset, command stimulus, back-pressure and verdict.

module ordered_value_list_test;
    import ovl_pkg::*;

    // code 3 is left unused by the block and must be ignored
    localparam logic [1:0] CMD_UNUSED = 2'd3;

    localparam int RandomItems = 420;
    localparam int PhaseItems  = 60;
    localparam int HoldCycles  = 400;
    localparam int TailCycles  = 80;
    localparam int PoolSize    = 8;

    logic             i_clk         = 1'b0;
    logic             i_rst_n       = 1'b0;
    logic             s_axis_tvalid = 1'b0;
    logic             s_axis_tready;
    logic [DataW-1:0] s_axis_tdata  = '0;   // [31:0] value
    logic [1:0]       s_axis_tuser  = '0;   // [1:0] command
    logic             m_axis_tvalid;
    logic             m_axis_tready = 1'b0;
    logic [DataW-1:0] m_axis_tdata;         // [31:0] entry_value
    logic [2:0]       m_axis_tuser;         // [1:0] status, [2] has_entry
    logic             m_axis_tlast;

    int pending;
    int fail_count;

    // idle rates in percent, changed per phase by the stimulus process
    int send_idle_pct  = 0;
    int recv_stall_pct = 0;

    // long receiver hold-off, requested by the stimulus, timed by its own process
    bit   hold_go   = 1'b0;
    logic recv_hold = 1'b0;

    // a small pool of values so that deletes often hit and duplicates build up
    logic [DataW-1:0] value_pool [PoolSize];

    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    ordered_value_list uut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

    ovl_checker result_check (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd_valid  (s_axis_tvalid),
        .i_cmd_ready  (s_axis_tready),
        .i_cmd_data   (s_axis_tdata),
        .i_cmd_user   (s_axis_tuser),
        .i_res_valid  (m_axis_tvalid),
        .i_res_ready  (m_axis_tready),
        .i_res_data   (m_axis_tdata),
        .i_res_user   (m_axis_tuser),
        .i_res_last   (m_axis_tlast),
        .o_pending    (pending),
        .o_fail_count (fail_count)
    );

    // Receiver: random stalls at the phase rate, forced low during the hold-off
    always @(posedge i_clk) begin
        m_axis_tready <= !recv_hold && ($urandom_range(99) >= recv_stall_pct);
    end

    // Hold-off: the result side stops for a long stretch while commands keep coming,
    // so the block backs up and drops s_axis_tready
    initial begin
        wait (hold_go);
        @(posedge i_clk);
        recv_hold <= 1'b1;
        repeat (HoldCycles) @(posedge i_clk);
        recv_hold <= 1'b0;
    end

    // Offer one command and return once it has been taken. Valid is only lowered
    // when an idle gap follows, so back-to-back commands keep it high throughout.
    task automatic offer_command(input logic [1:0] cmd, input logic [DataW-1:0] val);
        bit lowered;
        lowered = 1'b0;
        while ($urandom_range(99) < send_idle_pct) begin
            if (!lowered) begin
                s_axis_tvalid <= 1'b0;
                lowered = 1'b1;
            end
            @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= val;
        s_axis_tuser  <= cmd;
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
    endtask

    // Stimulus
    initial begin
        int               phase;
        int               item;
        int               append_pct;
        int               pick;
        logic [1:0]       cmd;
        logic [DataW-1:0] val;

        value_pool[0] = 32'h8000_0000;
        value_pool[1] = 32'h7FFF_FFFF;
        value_pool[2] = 32'h0000_0000;
        value_pool[3] = 32'hFFFF_FFFF;
        for (int k = 4; k < PoolSize; k++)
            value_pool[k] = $urandom();

        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed: empty list cases first
        offer_command(CMD_READ, 32'h0);
        offer_command(CMD_DELETE, 32'h7FFF_FFFF);
        // extremes of the value field, with a duplicate of the maximum
        offer_command(CMD_APPEND, 32'h8000_0000);
        offer_command(CMD_APPEND, 32'h7FFF_FFFF);
        offer_command(CMD_APPEND, 32'h0000_0000);
        offer_command(CMD_APPEND, 32'hFFFF_FFFF);
        offer_command(CMD_APPEND, 32'h7FFF_FFFF);
        // only the earlier duplicate goes
        offer_command(CMD_DELETE, 32'h7FFF_FFFF);
        offer_command(CMD_DELETE, 32'd12345);
        offer_command(CMD_READ, 32'hFFFF_FFFF);
        offer_command(CMD_UNUSED, 32'h5A5A_A5A5);
        // fill to capacity, then try one more and read the full list
        for (int k = 0; k < DEPTH - 4; k++)
            offer_command(CMD_APPEND, $urandom());
        offer_command(CMD_APPEND, 32'h1234_5678);
        offer_command(CMD_READ, 32'h0);

        // Random phases: idling pattern cycles through the four modes;
        // the append share varies so the list swings between empty and full
        for (phase = 0; phase < RandomItems / PhaseItems; phase++) begin
            case (phase % 4)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 74; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 74; end
                default: begin send_idle_pct = 6; recv_stall_pct = 6; end
            endcase
            if (phase == 4)
                hold_go = 1'b1;
            for (item = 0; item < PhaseItems; item++) begin
                if (item % 20 == 0)
                    append_pct = $urandom_range(25, 60);
                pick = $urandom_range(99);
                if (pick < 3)
                    cmd = CMD_UNUSED;
                else if (pick < 15)
                    cmd = CMD_READ;
                else if (pick < 15 + append_pct)
                    cmd = CMD_APPEND;
                else
                    cmd = CMD_DELETE;
                if ($urandom_range(99) < 70)
                    val = value_pool[$urandom_range(PoolSize - 1)];
                else
                    val = $urandom();
                offer_command(cmd, val);
            end
        end

        s_axis_tvalid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (TailCycles) @(posedge i_clk);

        if (fail_count == 0)
            $display("[ordered_value_list] OK");
        else
            $display("[ordered_value_list] ERROR");
        $finish;
    end

    // Watchdog: far beyond the slowest correct run
    initial begin
        #4_000_000;
        $display("[ordered_value_list] ERROR");
        $finish;
    end

endmodule
